// File: rtl/core/adc_average_quadratic_calibration_assert.svh
// Assertion macros used by the back part of the ADC averaging and calibration RTL.
`ifndef ADC_AVERAGE_QUADRATIC_CALIBRATION_ASSERT_SVH
`define ADC_AVERAGE_QUADRATIC_CALIBRATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AAQC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define AAQC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AAQC_ASSERT(label, prop, msg)
`define AAQC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/core/aaqc_pkg.sv
// Shared types and constants of the ADC averaging and calibration block.
`default_nettype none
package aaqc_pkg;
    localparam int NUM_CH     = 5;
    localparam int NUM_SLOTS  = 5;
    localparam int SUM_W      = 18;
    localparam int COEF_IDX_W = 5;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // item kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // coefficient slots
    localparam logic [2:0] SLOT_K    = 3'd0;
    localparam logic [2:0] SLOT_P2   = 3'd1;
    localparam logic [2:0] SLOT_P1   = 3'd2;
    localparam logic [2:0] SLOT_P0   = 3'd3;
    localparam logic [2:0] SLOT_ZERO = 3'd4;

    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        t_sum [NUM_CH-1:0] sums;
    } t_job;

    typedef struct packed {
        logic                  we;
        logic [COEF_IDX_W-1:0] idx;
        logic [31:0]           data;
    } t_coef_wr;

    typedef struct packed {
        logic busy;
    } t_back_status;
endpackage
`default_nettype wire

// File: rtl/core/aaqc_queue.sv
// Two-entry job queue between the front and back parts.
`default_nettype none
module aaqc_queue #(
    parameter int WIDTH = 90
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    // store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/aaqc_front.sv
// Front part: accepts items, accumulates samples, routes coefficient writes.
`default_nettype none
module aaqc_front import aaqc_pkg::*; #(
    parameter int CURRENT_CHANNEL_COUNT = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic         i_req_type,
    input  wire logic [2:0]   i_channel,
    input  wire logic [11:0]  i_sample,
    input  wire logic         i_frame_end,
    input  wire logic [2:0]   i_coeff_slot,
    input  wire logic [31:0]  i_coeff_value,
    output logic              o_push,
    output t_job              o_job,
    input  wire logic         i_q_full,
    input  wire logic         i_q_empty,
    input  wire t_back_status i_back,
    output t_coef_wr          o_coef
);
    localparam logic [2:0] LAST_CH = 3'(CURRENT_CHANNEL_COUNT);

    t_sum        r_sums [NUM_CH];
    t_sum        n_sums [NUM_CH];
    logic        acc;

    // coefficient writes wait until no frame is pending or in work
    always_comb begin
        if (i_req_type == REQ_COEF) begin
            o_ready = i_q_empty && !i_back.busy;
        end else begin
            o_ready = !i_frame_end || !i_q_full;
        end
    end

    assign acc = i_valid && o_ready;

    always_comb begin
        o_coef.we   = acc && (i_req_type == REQ_COEF) &&
                      (i_channel < 3'(NUM_CH)) && (i_coeff_slot < 3'(NUM_SLOTS));
        o_coef.idx  = COEF_IDX_W'({2'b00, i_channel} * 5'(NUM_SLOTS)) +
                      COEF_IDX_W'(i_coeff_slot);
        o_coef.data = i_coeff_value;
    end

    // add the sample with saturation
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            n_sums[i] = r_sums[i];
            if (acc && (i_req_type == REQ_SAMPLE) && (i_channel <= LAST_CH) &&
                (i_channel == 3'(i))) begin
                n_sums[i] = t_sum'(({1'b0, r_sums[i]} + 19'(i_sample)) > 19'(SUM_MAX) ?
                                   SUM_MAX : r_sums[i] + t_sum'(i_sample));
            end
            o_job.sums[i] = n_sums[i];
        end
    end

    assign o_push = acc && (i_req_type == REQ_SAMPLE) && i_frame_end;

    // hold sums, clear them when a frame is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_sums[i] <= o_push ? t_sum'(0) : n_sums[i];
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/aaqc_back.sv
// Back part: per-channel mean, offset, scaling and quadratic correction.
`default_nettype none
`include "adc_average_quadratic_calibration_assert.svh"
module aaqc_back import aaqc_pkg::*; #(
    parameter int VOLTAGE_SAMPLES       = 64,
    parameter int CURRENT_SAMPLES       = 128,
    parameter int CURRENT_CHANNEL_COUNT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_empty,
    input  wire t_job        i_job,
    output logic             o_pop,
    input  wire t_coef_wr    i_coef,
    input  wire logic [31:0] i_adc_lsb_scale,
    input  wire logic [31:0] i_shunt_conductance,
    output t_back_status     o_status,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_channel,
    output logic [31:0]      o_value,
    output logic             o_last
);
    localparam int N_VOLT = VOLTAGE_SAMPLES;
    localparam int N_CURR = (CURRENT_SAMPLES / 2 == 0) ? 1 : CURRENT_SAMPLES / 2;
    localparam int N_MAX  = N_VOLT > N_CURR ? N_VOLT : N_CURR;
    localparam int NW     = $clog2(N_MAX + 1);
    localparam int DW     = SUM_W + 16;
    localparam int XW     = NW + 16;
    localparam int QW     = SUM_W + NW;
    localparam int R1W    = SUM_W + 1;
    localparam int P1W    = SUM_W + R1W;
    localparam int R2W    = XW + 1;
    localparam int P2W    = XW + R2W;
    localparam int L_V    = $clog2(N_VOLT);
    localparam int L_C    = $clog2(N_CURR);
    localparam int SH1_V  = SUM_W + L_V;
    localparam int SH1_C  = SUM_W + L_C;
    localparam int SH2_V  = XW + L_V;
    localparam int SH2_C  = XW + L_C;
    localparam longint R1_V = ((longint'(1) << SH1_V) + longint'(N_VOLT) - 1) /
                              longint'(N_VOLT);
    localparam longint R1_C = ((longint'(1) << SH1_C) + longint'(N_CURR) - 1) /
                              longint'(N_CURR);
    localparam longint R2_V = ((longint'(1) << SH2_V) + longint'(N_VOLT) - 1) /
                              longint'(N_VOLT);
    localparam longint R2_C = ((longint'(1) << SH2_C) + longint'(N_CURR) - 1) /
                              longint'(N_CURR);
    localparam logic [R1W-1:0] RCP1_V = R1W'(R1_V);
    localparam logic [R1W-1:0] RCP1_C = R1W'(R1_C);
    localparam logic [R2W-1:0] RCP2_V = R2W'(R2_V);
    localparam logic [R2W-1:0] RCP2_C = R2W'(R2_C);
    localparam logic [NW-1:0] DIV_V = NW'(N_VOLT);
    localparam logic [NW-1:0] DIV_C = NW'(N_CURR);
    localparam logic [2:0]    LAST_CH = 3'(CURRENT_CHANNEL_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_REM  = 3'd6;
    localparam logic [2:0] S_FRC  = 3'd7;

    localparam logic [2:0] OP_LSB = 3'd0;
    localparam logic [2:0] OP_K   = 3'd1;
    localparam logic [2:0] OP_G   = 3'd2;
    localparam logic [2:0] OP_SQ  = 3'd3;
    localparam logic [2:0] OP_P2  = 3'd4;
    localparam logic [2:0] OP_P1  = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       r_op;
    logic [2:0]       r_ch;
    t_job             r_job;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_qs;
    logic [NW-1:0]    r_rs;
    logic [DW-1:0]    r_quo;
    logic [31:0]      r_v;
    logic [31:0]      r_t;
    logic [31:0]      r_res;
    logic [63:0]      r_prod;
    logic             r_neg;
    logic [31:0]      r_tab [NUM_CH * NUM_SLOTS];

    // coefficient table, written from the front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH * NUM_SLOTS; i++) begin
                r_tab[i] <= '0;
            end
        end else if (i_coef.we) begin
            r_tab[i_coef.idx] <= i_coef.data;
        end
    end

    // select the slot the current step needs
    logic [2:0]            slot;
    logic [COEF_IDX_W-1:0] cidx;
    logic [31:0]           coef;
    always_comb begin
        case (r_op)
            OP_K:    slot = SLOT_K;
            OP_P2:   slot = SLOT_P2;
            default: slot = SLOT_P1;
        endcase
        if (r_state == S_SUB) begin
            slot = SLOT_ZERO;
        end else if (r_state == S_RND) begin
            slot = SLOT_P0;
        end
    end
    assign cidx = COEF_IDX_W'({2'b00, r_ch} * 5'(NUM_SLOTS)) + COEF_IDX_W'(slot);
    assign coef = r_tab[cidx];

    // mean divisor of a channel: VOLTAGE_SAMPLES on channel 0, half of CURRENT_SAMPLES on others
    function automatic logic [NW-1:0] divisor(input logic [2:0] ch);
        return (ch == 3'd0) ? DIV_V : DIV_C;
    endfunction

    // mean by reciprocal multiplication: whole part, remainder, then fraction
    logic [R1W-1:0]   rcp1;
    logic [P1W-1:0]   prod1;
    logic [SUM_W-1:0] qs;
    logic [QW-1:0]    qn;
    logic [XW-1:0]    x2;
    logic [R2W-1:0]   rcp2;
    logic [P2W-1:0]   prod2;
    logic [15:0]      qf;
    assign rcp1  = (r_ch == 3'd0) ? RCP1_V : RCP1_C;
    assign prod1 = P1W'(r_sum) * P1W'(rcp1);
    assign qs    = (r_ch == 3'd0) ? SUM_W'(prod1 >> SH1_V) : SUM_W'(prod1 >> SH1_C);
    assign qn    = QW'(r_qs) * QW'(divisor(r_ch));
    assign x2    = {r_rs, 16'h0000} + XW'(divisor(r_ch) >> 1);
    assign rcp2  = (r_ch == 3'd0) ? RCP2_V : RCP2_C;
    assign prod2 = P2W'(x2) * P2W'(rcp2);
    assign qf    = (r_ch == 3'd0) ? 16'(prod2 >> SH2_V) : 16'(prod2 >> SH2_C);

    // mean clamp and offset subtract
    logic [31:0] mean;
    logic [33:0] diff;
    logic [31:0] diff_sat;
    assign mean = (r_quo > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_quo[31:0];
    assign diff = {2'b00, mean} - {{2{coef[31]}}, coef};
    assign diff_sat = (diff[33] && !diff[31]) ? 32'h8000_0000 :
                      (!diff[33] && diff[31]) ? 32'h7FFF_FFFF : diff[31:0];

    // multiplier operands
    logic [31:0] opa;
    logic [32:0] opb;
    logic [31:0] ua;
    logic [32:0] nb;
    logic [31:0] ub;
    always_comb begin
        opa = (r_op == OP_P2) ? r_t : r_v;
        case (r_op)
            OP_LSB:  opb = {1'b0, i_adc_lsb_scale};
            OP_K:    opb = {coef[31], coef};
            OP_G:    opb = {1'b0, i_shunt_conductance};
            OP_SQ:   opb = {r_v[31], r_v};
            default: opb = {coef[31], coef};
        endcase
    end
    assign ua = opa[31] ? (~opa + 32'd1) : opa;
    assign nb = ~opb + 33'd1;
    assign ub = opb[32] ? nb[31:0] : opb[31:0];

    // rounding, clamp and sign of the registered product
    logic [63:0] rsum;
    logic [47:0] q48;
    logic [31:0] qc;
    logic [31:0] res;
    logic [33:0] tot;
    logic [31:0] tot_sat;
    assign rsum = r_prod + ((r_op == OP_LSB) ? 64'h8000_0000 : 64'h0000_8000);
    assign q48  = (r_op == OP_LSB) ? {16'h0000, rsum[63:32]} : rsum[63:16];
    assign qc   = (q48 > 48'h8000_0000) ? 32'h8000_0000 : q48[31:0];
    assign res  = r_neg ? (~qc + 32'd1) : (qc[31] ? 32'h7FFF_FFFF : qc);
    assign tot  = {{2{r_t[31]}}, r_t} + {{2{res[31]}}, res} + {{2{coef[31]}}, coef};
    assign tot_sat = ((tot[33:31] == 3'b000) || (tot[33:31] == 3'b111)) ? tot[31:0] :
                     (tot[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;
    assign o_status.busy = (r_state != S_IDLE);

    logic out_free;
    assign out_free = !o_valid || i_ready;

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LSB;
            r_ch    <= 3'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_ch    <= 3'd0;
                        r_sum   <= i_job.sums[0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_qs    <= qs;
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rs    <= NW'(QW'(r_sum) - qn);
                    r_state <= S_FRC;
                end
                S_FRC: begin
                    r_quo   <= {r_qs, qf};
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_v     <= diff_sat;
                    r_op    <= OP_LSB;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= 64'(ua) * 64'(ub);
                    r_neg   <= opa[31] ^ opb[32];
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_state <= S_MUL;
                    case (r_op)
                        OP_LSB: begin
                            r_v  <= res;
                            r_op <= OP_K;
                        end
                        OP_K: begin
                            r_v  <= res;
                            r_op <= (r_ch == 3'd0) ? OP_SQ : OP_G;
                        end
                        OP_G: begin
                            r_v  <= res;
                            r_op <= OP_SQ;
                        end
                        OP_SQ: begin
                            r_t  <= res;
                            r_op <= OP_P2;
                        end
                        OP_P2: begin
                            r_t  <= res;
                            r_op <= OP_P1;
                        end
                        default: begin
                            r_res   <= tot_sat;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_ch == LAST_CH) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch    <= r_ch + 3'd1;
                            r_sum   <= r_job.sums[r_ch + 3'd1];
                            r_state <= S_DIV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            o_channel <= r_ch;
            o_value   <= r_res;
            o_last    <= (r_ch == LAST_CH);
        end
    end

    `AAQC_ASSERT(a_pop_idle, o_pop |-> (r_state == S_IDLE), "job taken while busy")
    `AAQC_ASSERT(a_rem_range, (r_state == S_FRC) |-> (r_rs < divisor(r_ch)), "remainder out of range")
    `AAQC_ASSERT(a_last_ch, (o_valid && o_last) |-> (o_channel == LAST_CH), "last on wrong channel")
    `AAQC_ASSERT(a_out_load, ((r_state == S_OUT) && out_free) |=> o_valid, "result lost")
endmodule
`default_nettype wire

// File: rtl/core/adc_average_quadratic_calibration.sv
// Top level of the ADC frame averaging and quadratic calibration block.
//
// Usage:
//  - s_axis carries items: tuser = item kind (0 sample, 1 coefficient write),
//    tlast = frame end on a sample item, tdata = channel, sample, slot, value.
//  - A sample item is taken and added to its channel sum. A
//    frame-end sample hands the sums to a two-deep frame queue and clears them.
//  - Each queued frame gives 1+CURRENT_CHANNEL_COUNT results on m_axis in
//    channel order, tlast on the final one. Each channel passes through the
//    mean by reciprocal multiplication, the offset subtract, the multiply
//    steps through one shared multiplier and the output register; a current
//    channel also multiplies by the shunt conductance.
//  - A coefficient item waits until no frame is queued or in work.
//  - When m_axis stalls, the result register holds and the back part waits;
//    samples are still taken; only a frame-end sample waits while the frame queue is full.
//  - Reset clears sums, coefficients and queue and loads the register reset values;
//    the user writes registers on the cfg channel only while idle; the block does not enforce it.
`default_nettype none
module adc_average_quadratic_calibration import aaqc_pkg::*; #(
    parameter int VOLTAGE_SAMPLES       = 64,
    parameter int CURRENT_SAMPLES       = 128,
    parameter int CURRENT_CHANNEL_COUNT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: channel[2:0], sample[14:3], coeff_slot[17:15], coeff_value[49:18]
    input  wire logic [55:0] s_axis_tdata,
    // tuser: req_type
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_channel[2:0], value[34:3]
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam logic CFG_LSB   = 1'b0;
    localparam logic CFG_SHUNT = 1'b1;

    logic [31:0]  r_adc_lsb_scale;
    logic [31:0]  r_shunt_conductance;
    logic         push;
    t_job         job_in;
    t_job         job_out;
    logic         q_full;
    logic         q_empty;
    logic         pop;
    t_back_status back_st;
    t_coef_wr     coef_wr;
    logic [2:0]   out_ch;
    logic [31:0]  out_val;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_lsb_scale     <= 32'd3460301;
            r_shunt_conductance <= 32'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LSB:   r_adc_lsb_scale     <= i_cfg_data;
                CFG_SHUNT: r_shunt_conductance <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    aaqc_front #(
        .CURRENT_CHANNEL_COUNT(CURRENT_CHANNEL_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_channel    (s_axis_tdata[2:0]),
        .i_sample     (s_axis_tdata[14:3]),
        .i_frame_end  (s_axis_tlast),
        .i_coeff_slot (s_axis_tdata[17:15]),
        .i_coeff_value(s_axis_tdata[49:18]),
        .o_push       (push),
        .o_job        (job_in),
        .i_q_full     (q_full),
        .i_q_empty    (q_empty),
        .i_back       (back_st),
        .o_coef       (coef_wr)
    );

    aaqc_queue #(
        .WIDTH($bits(t_job))
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (job_in),
        .o_full (q_full),
        .i_pop  (pop),
        .o_data (job_out),
        .o_empty(q_empty)
    );

    aaqc_back #(
        .VOLTAGE_SAMPLES      (VOLTAGE_SAMPLES),
        .CURRENT_SAMPLES      (CURRENT_SAMPLES),
        .CURRENT_CHANNEL_COUNT(CURRENT_CHANNEL_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_job              (job_out),
        .o_pop              (pop),
        .i_coef             (coef_wr),
        .i_adc_lsb_scale    (r_adc_lsb_scale),
        .i_shunt_conductance(r_shunt_conductance),
        .o_status           (back_st),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_channel          (out_ch),
        .o_value            (out_val),
        .o_last             (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, out_val, out_ch};
endmodule
`default_nettype wire
